// ===== rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared sizes, codes, controller states and the command and status words
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package scc_pkg;

   localparam int MAX_V = 64;
   localparam int VW    = $clog2(MAX_V);
   localparam int FW    = 6;
   localparam int CW    = 7;
   localparam int MAPW  = 64;

   localparam logic [CW-1:0] VC_RESET = CW'(MAX_V);

   localparam logic [1:0] REQ_EDGE    = 2'd0;
   localparam logic [1:0] REQ_COMPUTE = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_VERTEX    = 2'd1;
   localparam logic [1:0] ST_NOT_READY = 2'd2;
   localparam logic [1:0] ST_COMP      = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_EDGE_RD,
      OP_EDGE_WR,
      OP_RD_ROW,
      OP_C_INIT,
      OP_NEXT_V,
      OP_START_V,
      OP_START_A,
      OP_ROW_RD,
      OP_OPEN,
      OP_PUSH,
      OP_POP,
      OP_CUR_LOAD,
      OP_WALK_END,
      OP_P2_INIT,
      OP_FIN_RD,
      OP_NM_INIT,
      OP_NM_RD,
      OP_NM_NEW,
      OP_NM_MEM,
      OP_NM_OLD_RD,
      OP_NM_OLD,
      OP_V_CLR,
      OP_CL_WR,
      OP_CD_RD,
      OP_CD_ROW,
      OP_CD_ACC,
      OP_CD_BIT,
      OP_CD_CMP,
      OP_CD_WR,
      OP_FINISH
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_EDGE_WR,
      S_RESP,
      S_P1_SCAN,
      S_W_RD,
      S_W_OPEN,
      S_W_STEP,
      S_W_POP,
      S_W_END,
      S_P2_SCAN,
      S_P2_CHECK,
      S_NM_RD,
      S_NM_CHK,
      S_NM_MEM,
      S_NM_OLD,
      S_CL,
      S_CD_U,
      S_CD_ROW,
      S_CD_ACC,
      S_CD_BIT,
      S_CD_CMP
   } state_type;

   typedef struct packed {
      op_type     op;
      logic       set_stat;
      logic [1:0] status;
      logic       map_ok;
      logic       resp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_kind;
      logic       vertex_bad;
      logic       not_ready;
      logic       comp_bad;
      logic       v_end;
      logic       visited_v;
      logic       visited_a;
      logic       ftop_zero;
      logic       scan_nz;
      logic       top_one;
      logic       named_r;
      logic       clr_end;
      logic       pass2;
      logic       out_free;
   } stat_type;

endpackage

// ===== rtl/scc_ctrl.sv =====
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer: decodes each request and steps the datapath through edge
// updates, row reads and the two search passes, naming and condensation.
// ----------------------------------------------------------------------------
module scc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scc_pkg::stat_type stat,
   output scc_pkg::cmd_type  cmd
);

   scc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = scc_pkg::OP_NONE;
      cmd.set_stat = 1'b0;
      cmd.status   = scc_pkg::ST_OK;
      cmd.map_ok   = 1'b0;
      cmd.resp     = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         scc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = scc_pkg::OP_LOAD;
               state_in = scc_pkg::S_DECODE;
            end
         end
         scc_pkg::S_DECODE: begin
            cmd.set_stat = 1'b1;
            case (stat.req_kind)
               scc_pkg::REQ_EDGE: begin
                  if (stat.vertex_bad) begin
                     cmd.status = scc_pkg::ST_VERTEX;
                     state_in   = scc_pkg::S_RESP;
                  end else begin
                     cmd.op   = scc_pkg::OP_EDGE_RD;
                     state_in = scc_pkg::S_EDGE_WR;
                  end
               end
               scc_pkg::REQ_COMPUTE: begin
                  cmd.op   = scc_pkg::OP_C_INIT;
                  state_in = scc_pkg::S_P1_SCAN;
               end
               scc_pkg::REQ_READ: begin
                  state_in = scc_pkg::S_RESP;
                  if (stat.not_ready) begin
                     cmd.status = scc_pkg::ST_NOT_READY;
                  end else if (stat.comp_bad) begin
                     cmd.status = scc_pkg::ST_COMP;
                  end else begin
                     cmd.op     = scc_pkg::OP_RD_ROW;
                     cmd.map_ok = 1'b1;
                  end
               end
               default: begin
                  state_in = scc_pkg::S_RESP;
               end
            endcase
         end
         scc_pkg::S_EDGE_WR: begin
            cmd.op   = scc_pkg::OP_EDGE_WR;
            state_in = scc_pkg::S_RESP;
         end
         scc_pkg::S_RESP: begin
            if (stat.out_free) begin
               cmd.resp = 1'b1;
               state_in = scc_pkg::S_IDLE;
            end
         end
         scc_pkg::S_P1_SCAN: begin
            if (stat.v_end) begin
               cmd.op   = scc_pkg::OP_P2_INIT;
               state_in = scc_pkg::S_P2_SCAN;
            end else if (stat.visited_v) begin
               cmd.op = scc_pkg::OP_NEXT_V;
            end else begin
               cmd.op   = scc_pkg::OP_START_V;
               state_in = scc_pkg::S_W_RD;
            end
         end
         scc_pkg::S_W_RD: begin
            cmd.op   = scc_pkg::OP_ROW_RD;
            state_in = scc_pkg::S_W_OPEN;
         end
         scc_pkg::S_W_OPEN: begin
            cmd.op   = scc_pkg::OP_OPEN;
            state_in = scc_pkg::S_W_STEP;
         end
         scc_pkg::S_W_STEP: begin
            if (stat.scan_nz) begin
               cmd.op   = scc_pkg::OP_PUSH;
               state_in = scc_pkg::S_W_RD;
            end else begin
               cmd.op   = scc_pkg::OP_POP;
               state_in = stat.top_one ? scc_pkg::S_W_END : scc_pkg::S_W_POP;
            end
         end
         scc_pkg::S_W_POP: begin
            cmd.op   = scc_pkg::OP_CUR_LOAD;
            state_in = scc_pkg::S_W_RD;
         end
         scc_pkg::S_W_END: begin
            cmd.op   = scc_pkg::OP_WALK_END;
            state_in = stat.pass2 ? scc_pkg::S_P2_SCAN : scc_pkg::S_P1_SCAN;
         end
         scc_pkg::S_P2_SCAN: begin
            if (stat.ftop_zero) begin
               cmd.op   = scc_pkg::OP_NM_INIT;
               state_in = scc_pkg::S_NM_RD;
            end else begin
               cmd.op   = scc_pkg::OP_FIN_RD;
               state_in = scc_pkg::S_P2_CHECK;
            end
         end
         scc_pkg::S_P2_CHECK: begin
            if (stat.visited_a) begin
               state_in = scc_pkg::S_P2_SCAN;
            end else begin
               cmd.op   = scc_pkg::OP_START_A;
               state_in = scc_pkg::S_W_RD;
            end
         end
         scc_pkg::S_NM_RD: begin
            if (stat.v_end) begin
               cmd.op   = scc_pkg::OP_V_CLR;
               state_in = scc_pkg::S_CL;
            end else begin
               cmd.op   = scc_pkg::OP_NM_RD;
               state_in = scc_pkg::S_NM_CHK;
            end
         end
         scc_pkg::S_NM_CHK: begin
            if (stat.named_r) begin
               cmd.op   = scc_pkg::OP_NM_OLD_RD;
               state_in = scc_pkg::S_NM_OLD;
            end else begin
               cmd.op   = scc_pkg::OP_NM_NEW;
               state_in = scc_pkg::S_NM_MEM;
            end
         end
         scc_pkg::S_NM_MEM: begin
            cmd.op   = scc_pkg::OP_NM_MEM;
            state_in = scc_pkg::S_NM_RD;
         end
         scc_pkg::S_NM_OLD: begin
            cmd.op   = scc_pkg::OP_NM_OLD;
            state_in = scc_pkg::S_NM_RD;
         end
         scc_pkg::S_CL: begin
            if (stat.clr_end) begin
               cmd.op   = scc_pkg::OP_V_CLR;
               state_in = scc_pkg::S_CD_U;
            end else begin
               cmd.op = scc_pkg::OP_CL_WR;
            end
         end
         scc_pkg::S_CD_U: begin
            if (stat.v_end) begin
               cmd.op   = scc_pkg::OP_FINISH;
               state_in = scc_pkg::S_RESP;
            end else begin
               cmd.op   = scc_pkg::OP_CD_RD;
               state_in = scc_pkg::S_CD_ROW;
            end
         end
         scc_pkg::S_CD_ROW: begin
            cmd.op   = scc_pkg::OP_CD_ROW;
            state_in = scc_pkg::S_CD_ACC;
         end
         scc_pkg::S_CD_ACC: begin
            cmd.op   = scc_pkg::OP_CD_ACC;
            state_in = scc_pkg::S_CD_BIT;
         end
         scc_pkg::S_CD_BIT: begin
            if (stat.scan_nz) begin
               cmd.op   = scc_pkg::OP_CD_BIT;
               state_in = scc_pkg::S_CD_CMP;
            end else begin
               cmd.op   = scc_pkg::OP_CD_WR;
               state_in = scc_pkg::S_CD_U;
            end
         end
         scc_pkg::S_CD_CMP: begin
            cmd.op   = scc_pkg::OP_CD_CMP;
            state_in = scc_pkg::S_CD_BIT;
         end
         default: begin
            state_in = scc_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/scc_datapath.sv =====
// ----------------------------------------------------------------------------
// scc_datapath
// Adjacency stores, search stacks, component tables, counters and the
// result register, driven at most one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module scc_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                req_type,
   input  logic [scc_pkg::FW-1:0]    req_from_vertex,
   input  logic [scc_pkg::FW-1:0]    req_to_vertex,
   input  logic [scc_pkg::FW-1:0]    req_comp_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [scc_pkg::CW-1:0]    rsp_component_count,
   output logic [scc_pkg::MAPW-1:0]  rsp_member_map,
   output logic [scc_pkg::MAPW-1:0]  rsp_successor_map,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [scc_pkg::CW-1:0]    csr_vertex_count,
   input  scc_pkg::cmd_type          cmd,
   output scc_pkg::stat_type         stat
);

   localparam int MV = scc_pkg::MAX_V;
   localparam int VW = scc_pkg::VW;
   localparam int CW = scc_pkg::CW;
   localparam int FW = scc_pkg::FW;

   // graph stores with per-row valid bits
   logic [MV-1:0] fwd_mem [MV];
   logic [MV-1:0] rev_mem [MV];
   logic [MV-1:0] fwd_vld_ff, rev_vld_ff;
   logic [MV-1:0] fwd_rd_ff, rev_rd_ff;

   logic [VW-1:0] walk_mem   [MV];
   logic [VW-1:0] fin_mem    [MV];
   logic [VW-1:0] rawof_mem  [MV];
   logic [MV-1:0] raw_mem    [MV];
   logic [VW-1:0] newid_mem  [MV];
   logic [VW-1:0] comp_mem   [MV];
   logic [MV-1:0] member_mem [MV];
   logic [MV-1:0] cond_mem   [MV];

   logic [VW-1:0] walk_rd_ff, fin_rd_ff, rawof_rd_ff, newid_rd_ff, comp_rd_ff;
   logic [MV-1:0] raw_rd_ff, member_rd_ff, cond_rd_ff;

   logic [CW-1:0] vc_ff, found_ff;
   logic          result_ready_ff;
   logic [1:0]    req_kind_ff;
   logic [FW-1:0] from_ff, to_ff, ci_ff;
   logic [1:0]    status_ff;
   logic          map_ok_ff;

   logic [CW-1:0] v_ff, top_ff, ftop_ff, raw_cnt_ff, cnt_ff;
   logic [VW-1:0] cur_ff, cu_ff;
   logic [MV-1:0] visited_ff, reached_ff, named_ff, scan_ff, acc_ff;
   logic          pass2_ff;

   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_status_ff;
   logic [CW-1:0]               rsp_count_ff;
   logic [scc_pkg::MAPW-1:0]    rsp_member_ff, rsp_succ_ff;

   logic [CW-1:0] n_val;
   logic [MV-1:0] mask;
   logic [VW-1:0] lo_idx;
   logic [MV-1:0] lo_bit;
   logic [VW-1:0] start_src;
   logic [VW-1:0] from_idx, to_idx, ci_idx, v_idx;

   assign from_idx = from_ff[VW-1:0];
   assign to_idx   = to_ff[VW-1:0];
   assign ci_idx   = ci_ff[VW-1:0];
   assign v_idx    = v_ff[VW-1:0];

   always_comb begin
      if (vc_ff == '0) begin
         n_val = CW'(1);
      end else if (vc_ff > CW'(MV)) begin
         n_val = CW'(MV);
      end else begin
         n_val = vc_ff;
      end
      for (int i = 0; i < MV; i++) begin
         mask[i] = (CW'(i) < n_val);
      end
   end

   // lowest set bit of the scan word
   always_comb begin
      lo_idx = '0;
      for (int i = MV - 1; i >= 0; i--) begin
         if (scan_ff[i]) begin
            lo_idx = VW'(i);
         end
      end
      lo_bit = MV'(1) << lo_idx;
   end

   assign start_src = (cmd.op == scc_pkg::OP_START_A) ? fin_rd_ff : v_idx;

   always_ff @(posedge clock) begin
      if (cmd.set_stat) begin
         status_ff <= cmd.status;
         map_ok_ff <= cmd.map_ok;
      end
      if (cmd.resp) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= result_ready_ff ? found_ff : '0;
         rsp_member_ff <= map_ok_ff ? scc_pkg::MAPW'(member_rd_ff) : '0;
         rsp_succ_ff   <= map_ok_ff ? scc_pkg::MAPW'(cond_rd_ff) : '0;
      end
      case (cmd.op)
         scc_pkg::OP_LOAD: begin
            req_kind_ff <= req_type;
            from_ff     <= req_from_vertex;
            to_ff       <= req_to_vertex;
            ci_ff       <= req_comp_index;
         end
         scc_pkg::OP_EDGE_RD: begin
            fwd_rd_ff <= fwd_vld_ff[from_idx] ? fwd_mem[from_idx] : '0;
            rev_rd_ff <= rev_vld_ff[to_idx] ? rev_mem[to_idx] : '0;
         end
         scc_pkg::OP_EDGE_WR: begin
            fwd_mem[from_idx] <= fwd_rd_ff | (MV'(1) << to_idx);
            rev_mem[to_idx]   <= rev_rd_ff | (MV'(1) << from_idx);
         end
         scc_pkg::OP_RD_ROW: begin
            member_rd_ff <= member_mem[ci_idx];
            cond_rd_ff   <= cond_mem[ci_idx];
         end
         scc_pkg::OP_C_INIT: begin
            visited_ff <= '0;
            v_ff       <= '0;
            ftop_ff    <= '0;
            pass2_ff   <= 1'b0;
         end
         scc_pkg::OP_NEXT_V: begin
            v_ff <= v_ff + CW'(1);
         end
         scc_pkg::OP_START_V, scc_pkg::OP_START_A: begin
            walk_mem[0] <= start_src;
            top_ff      <= CW'(1);
            cur_ff      <= start_src;
            visited_ff  <= visited_ff | (MV'(1) << start_src);
            reached_ff  <= MV'(1) << start_src;
            if (pass2_ff) begin
               rawof_mem[start_src] <= raw_cnt_ff[VW-1:0];
            end
         end
         scc_pkg::OP_ROW_RD: begin
            fwd_rd_ff <= fwd_vld_ff[cur_ff] ? fwd_mem[cur_ff] : '0;
            rev_rd_ff <= rev_vld_ff[cur_ff] ? rev_mem[cur_ff] : '0;
         end
         scc_pkg::OP_OPEN: begin
            scan_ff <= (pass2_ff ? rev_rd_ff : fwd_rd_ff) & mask & ~visited_ff;
         end
         scc_pkg::OP_PUSH: begin
            visited_ff               <= visited_ff | lo_bit;
            reached_ff               <= reached_ff | lo_bit;
            walk_mem[top_ff[VW-1:0]] <= lo_idx;
            top_ff                   <= top_ff + CW'(1);
            cur_ff                   <= lo_idx;
            if (pass2_ff) begin
               rawof_mem[lo_idx] <= raw_cnt_ff[VW-1:0];
            end
         end
         scc_pkg::OP_POP: begin
            top_ff     <= top_ff - CW'(1);
            walk_rd_ff <= walk_mem[VW'(top_ff - CW'(2))];
            if (!pass2_ff) begin
               fin_mem[ftop_ff[VW-1:0]] <= cur_ff;
               ftop_ff                  <= ftop_ff + CW'(1);
            end
         end
         scc_pkg::OP_CUR_LOAD: begin
            cur_ff <= walk_rd_ff;
         end
         scc_pkg::OP_WALK_END: begin
            if (pass2_ff) begin
               raw_mem[raw_cnt_ff[VW-1:0]] <= reached_ff;
               raw_cnt_ff                  <= raw_cnt_ff + CW'(1);
            end else begin
               v_ff <= v_ff + CW'(1);
            end
         end
         scc_pkg::OP_P2_INIT: begin
            visited_ff <= '0;
            pass2_ff   <= 1'b1;
            raw_cnt_ff <= '0;
         end
         scc_pkg::OP_FIN_RD: begin
            fin_rd_ff <= fin_mem[VW'(ftop_ff - CW'(1))];
            ftop_ff   <= ftop_ff - CW'(1);
         end
         scc_pkg::OP_NM_INIT: begin
            v_ff     <= '0;
            cnt_ff   <= '0;
            named_ff <= '0;
         end
         scc_pkg::OP_NM_RD: begin
            rawof_rd_ff <= rawof_mem[v_idx];
         end
         scc_pkg::OP_NM_NEW: begin
            named_ff[rawof_rd_ff]  <= 1'b1;
            newid_mem[rawof_rd_ff] <= cnt_ff[VW-1:0];
            comp_mem[v_idx]        <= cnt_ff[VW-1:0];
            raw_rd_ff              <= raw_mem[rawof_rd_ff];
         end
         scc_pkg::OP_NM_MEM: begin
            member_mem[cnt_ff[VW-1:0]] <= raw_rd_ff;
            cnt_ff                     <= cnt_ff + CW'(1);
            v_ff                       <= v_ff + CW'(1);
         end
         scc_pkg::OP_NM_OLD_RD: begin
            newid_rd_ff <= newid_mem[rawof_rd_ff];
         end
         scc_pkg::OP_NM_OLD: begin
            comp_mem[v_idx] <= newid_rd_ff;
            v_ff            <= v_ff + CW'(1);
         end
         scc_pkg::OP_V_CLR: begin
            v_ff <= '0;
         end
         scc_pkg::OP_CL_WR: begin
            cond_mem[v_idx] <= '0;
            v_ff            <= v_ff + CW'(1);
         end
         scc_pkg::OP_CD_RD: begin
            comp_rd_ff <= comp_mem[v_idx];
            fwd_rd_ff  <= fwd_vld_ff[v_idx] ? fwd_mem[v_idx] : '0;
         end
         scc_pkg::OP_CD_ROW: begin
            cu_ff      <= comp_rd_ff;
            scan_ff    <= fwd_rd_ff & mask;
            cond_rd_ff <= cond_mem[comp_rd_ff];
         end
         scc_pkg::OP_CD_ACC: begin
            acc_ff <= cond_rd_ff;
         end
         scc_pkg::OP_CD_BIT: begin
            scan_ff    <= scan_ff & ~lo_bit;
            comp_rd_ff <= comp_mem[lo_idx];
         end
         scc_pkg::OP_CD_CMP: begin
            if (comp_rd_ff != cu_ff) begin
               acc_ff <= acc_ff | (MV'(1) << comp_rd_ff);
            end
         end
         scc_pkg::OP_CD_WR: begin
            cond_mem[cu_ff] <= acc_ff;
            v_ff            <= v_ff + CW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff           <= scc_pkg::VC_RESET;
         fwd_vld_ff      <= '0;
         rev_vld_ff      <= '0;
         result_ready_ff <= 1'b0;
         found_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            vc_ff           <= csr_vertex_count;
            result_ready_ff <= 1'b0;
         end
         if (cmd.op == scc_pkg::OP_EDGE_WR) begin
            fwd_vld_ff[from_idx] <= 1'b1;
            rev_vld_ff[to_idx]   <= 1'b1;
            result_ready_ff      <= 1'b0;
         end
         if (cmd.op == scc_pkg::OP_FINISH) begin
            found_ff        <= cnt_ff;
            result_ready_ff <= 1'b1;
         end
         if (cmd.resp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_component_count = rsp_count_ff;
   assign rsp_member_map      = rsp_member_ff;
   assign rsp_successor_map   = rsp_succ_ff;

   assign stat.req_kind   = req_kind_ff;
   assign stat.vertex_bad = ({1'b0, from_ff} >= n_val) || ({1'b0, to_ff} >= n_val);
   assign stat.not_ready  = !result_ready_ff;
   assign stat.comp_bad   = ({1'b0, ci_ff} >= found_ff);
   assign stat.v_end      = (v_ff >= n_val);
   assign stat.visited_v  = visited_ff[v_idx];
   assign stat.visited_a  = visited_ff[fin_rd_ff];
   assign stat.ftop_zero  = (ftop_ff == '0);
   assign stat.scan_nz    = |scan_ff;
   assign stat.top_one    = (top_ff == CW'(1));
   assign stat.named_r    = named_ff[rawof_rd_ff];
   assign stat.clr_end    = (v_ff == CW'(MV));
   assign stat.pass2      = pass2_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.op == scc_pkg::OP_PUSH |-> top_ff < CW'(MV))
      else $error("walk stack depth beyond vertex count");

   a_push_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.op == scc_pkg::OP_PUSH |=> visited_ff[cur_ff] && reached_ff[cur_ff])
      else $error("pushed vertex not marked visited");

   a_finish_sets: assert property (@(posedge clock) disable iff (reset)
      cmd.op == scc_pkg::OP_FINISH |=> result_ready_ff && found_ff != '0)
      else $error("compute finished without components");

   a_edge_voids: assert property (@(posedge clock) disable iff (reset)
      cmd.op == scc_pkg::OP_EDGE_WR |=> !result_ready_ff)
      else $error("added edge left result valid");

endmodule

// ===== rtl/strongly_connected_condensation.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_condensation
// Directed graph store with strongly connected component search and
// condensation graph; results are read back one component row per request.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_type, from/to vertex, comp index
//   rsp      out  rsp_valid/rsp_ready    status, count, member/successor maps
//   csr      in   csr_valid/csr_ready    csr_vertex_count
//
// One request at a time. Compute runs two search passes over the vertices,
// then naming, then a sweep that clears all 64 condensed rows, and then
// condensation, which visits every stored edge between active vertices.
// Reset clears the edge store through row valid bits.
// A stalled response holds its register; the next request is still taken.
// ----------------------------------------------------------------------------
module strongly_connected_condensation (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic [scc_pkg::FW-1:0]    req_from_vertex,
   input  logic [scc_pkg::FW-1:0]    req_to_vertex,
   input  logic [scc_pkg::FW-1:0]    req_comp_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [scc_pkg::CW-1:0]    rsp_component_count,
   output logic [scc_pkg::MAPW-1:0]  rsp_member_map,
   output logic [scc_pkg::MAPW-1:0]  rsp_successor_map,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [scc_pkg::CW-1:0]    csr_vertex_count
);

   scc_pkg::cmd_type  cmd;
   scc_pkg::stat_type stat;

   scc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_type            (req_type),
      .req_from_vertex     (req_from_vertex),
      .req_to_vertex       (req_to_vertex),
      .req_comp_index      (req_comp_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_component_count (rsp_component_count),
      .rsp_member_map      (rsp_member_map),
      .rsp_successor_map   (rsp_successor_map),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_vertex_count    (csr_vertex_count),
      .cmd                 (cmd),
      .stat                (stat)
   );

endmodule

// ===== test/strongly_connected_condensation_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strongly_connected_condensation_tb
// Drives edge, compute, read and ignored requests plus vertex count writes
// into the component search block and checks every response word against a
// behavioral component search kept inside a small scoreboard class.
// ----------------------------------------------------------------------------
module strongly_connected_condensation_tb;

   localparam logic [1:0] REQ_IGNORED = 2'd3;
   localparam int LIMIT_CYCLES = 6000000;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  count;
      logic [63:0] members;
      logic [63:0] succ;
   } rsp_word_type;

   class scc_scoreboard;
      logic [6:0]   vcount;
      logic [63:0]  fwd [64];
      logic [63:0]  rev [64];
      logic [63:0]  comp_members [64];
      logic [63:0]  comp_succ [64];
      logic [6:0]   comps;
      bit           valid_result;
      rsp_word_type pending [$];
      int           mismatches;
      int           checked;

      function void clear();
         vcount = scc_pkg::VC_RESET;
         for (int i = 0; i < 64; i++) begin
            fwd[i] = '0;
            rev[i] = '0;
            comp_members[i] = '0;
            comp_succ[i] = '0;
         end
         comps = 0;
         valid_result = 0;
         pending.delete();
         mismatches = 0;
         checked = 0;
      endfunction

      function int active_n();
         if (vcount == 0) return 1;
         if (vcount > 64) return 64;
         return int'(vcount);
      endfunction

      function void write_count(logic [6:0] value);
         vcount = value;
         valid_result = 0;
      endfunction

      // explicit-stack depth-first walk, lowest open neighbor first
      function logic [63:0] walk(int start, bit use_rev, logic [63:0] mask,
                                 ref logic [63:0] seen, ref int order[$],
                                 input bit record);
         int stk[$];
         int u, v;
         logic [63:0] open, reached;
         reached = 64'd1 << start;
         seen |= reached;
         stk.insert(stk.size(), start);
         while (stk.size() > 0) begin
            u = stk[$];
            open = (use_rev ? rev[u] : fwd[u]) & mask & ~seen;
            if (open != 0) begin
               v = 0;
               while (!open[v]) v++;
               seen[v] = 1'b1;
               reached[v] = 1'b1;
               stk.insert(stk.size(), v);
            end else begin
               void'(stk.pop_back());
               if (record) order.insert(order.size(), u);
            end
         end
         return reached;
      endfunction

      function void find_components();
         int n, a, id;
         int order[$];
         int dummy[$];
         logic [63:0] mask, seen, set;
         logic [63:0] raw [$];
         int raw_of [64];
         int new_id [64];
         int comp_of [64];
         n = active_n();
         mask = (n >= 64) ? '1 : ((64'd1 << n) - 1);
         seen = 0;
         for (int v = 0; v < n; v++)
            if (!seen[v]) void'(walk(v, 0, mask, seen, order, 1));
         seen = 0;
         while (order.size() > 0) begin
            a = order.pop_back();
            if (!seen[a]) begin
               set = walk(a, 1, mask, seen, dummy, 0);
               for (int u = 0; u < n; u++) if (set[u]) raw_of[u] = raw.size();
               raw.insert(raw.size(), set);
            end
         end
         for (int i = 0; i < 64; i++) begin
            new_id[i] = -1;
            comp_members[i] = '0;
            comp_succ[i] = '0;
         end
         id = 0;
         for (int v = 0; v < n; v++) begin
            if (new_id[raw_of[v]] < 0) begin
               new_id[raw_of[v]] = id;
               comp_members[id] = raw[raw_of[v]];
               id++;
            end
            comp_of[v] = new_id[raw_of[v]];
         end
         for (int u = 0; u < n; u++)
            for (int v = 0; v < n; v++)
               if (fwd[u][v] && comp_of[u] != comp_of[v])
                  comp_succ[comp_of[u]][comp_of[v]] = 1'b1;
         comps = 7'(id);
         valid_result = 1;
      endfunction

      function void note_request(logic [1:0] kind, int from, int to, int ci);
         rsp_word_type w;
         int n;
         n = active_n();
         w = '0;
         if (kind == scc_pkg::REQ_EDGE) begin
            if (from >= n || to >= n) w.status = scc_pkg::ST_VERTEX;
            else begin
               fwd[from][to] = 1'b1;
               rev[to][from] = 1'b1;
               valid_result = 0;
            end
         end else if (kind == scc_pkg::REQ_COMPUTE) begin
            find_components();
         end else if (kind == scc_pkg::REQ_READ) begin
            if (!valid_result) w.status = scc_pkg::ST_NOT_READY;
            else if (ci >= comps) w.status = scc_pkg::ST_COMP;
            else begin
               w.members = comp_members[ci];
               w.succ = comp_succ[ci];
            end
         end
         w.count = valid_result ? comps : 7'd0;
         pending.insert(pending.size(), w);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type exp;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", got);
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp st=%0d cnt=%0d mem=%h suc=%h",
                         " / got st=%0d cnt=%0d mem=%h suc=%h"},
                        exp.status, exp.count, exp.members, exp.succ,
                        got.status, got.count, got.members, got.succ);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_type = '0;
   logic [5:0]  req_from_vertex = '0, req_to_vertex = '0, req_comp_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_component_count;
   logic [63:0] rsp_member_map, rsp_successor_map;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [6:0]  csr_vertex_count = '0;

   scc_scoreboard sb;
   int  cycle_count = 0;
   bit  calm = 0;
   int  computes = 0, config_writes = 0;

   always #2 clock = ~clock;

   strongly_connected_condensation u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_from_vertex(req_from_vertex), .req_to_vertex(req_to_vertex),
      .req_comp_index(req_comp_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_component_count(rsp_component_count),
      .rsp_member_map(rsp_member_map), .rsp_successor_map(rsp_successor_map),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_vertex_count(csr_vertex_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // response side: random stall bursts, none once the run turns calm
   initial begin
      int stall;
      sb = new();
      sb.clear();
      @(posedge clock);
      while (1) begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            stall = $urandom_range(1, 9);
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_status, rsp_component_count,
                               rsp_member_map, rsp_successor_map});
      end
   end

   // valid stays high from one word to the next unless an idle burst or a drain comes
   task automatic send(logic [1:0] kind, int from, int to, int ci);
      logic [5:0] f6, t6, c6;
      f6 = 6'(from);
      t6 = 6'(to);
      c6 = 6'(ci);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= kind;
      req_from_vertex <= f6;
      req_to_vertex <= t6;
      req_comp_index <= c6;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, int'(f6), int'(t6), int'(c6));
      if (kind == scc_pkg::REQ_COMPUTE) computes++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_count(logic [6:0] value);
      drain();
      csr_valid <= 1;
      csr_vertex_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.write_count(value);
      config_writes++;
   endtask

   // a ring over the n vertices with random chords and out-of-range edges
   task automatic random_phase(int n, int items);
      int k, a, b, r;
      k = 0;
      while (k < items) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            a = $urandom_range(0, n - 1);
            b = (r < 35) ? (a + 1) % n : $urandom_range(0, n - 1);
            if ($urandom_range(0, 15) == 0) b = $urandom_range(0, 63);
            send(scc_pkg::REQ_EDGE, a, b, $urandom_range(0, 63));
         end else if (r < 68) send(scc_pkg::REQ_COMPUTE, $urandom, $urandom, $urandom);
         else if (r < 97)
            send(scc_pkg::REQ_READ, $urandom, $urandom,
                 (r < 90) ? $urandom_range(0, n) : $urandom_range(0, 63));
         else send(REQ_IGNORED, $urandom, $urandom, $urandom);
         k++;
      end
      send(scc_pkg::REQ_COMPUTE, 0, 0, 0);
      for (int c = 0; c < n && c < 64; c++) send(scc_pkg::REQ_READ, 0, 0, c);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reads before compute, range errors, empty graph, rings
      send(scc_pkg::REQ_READ, 0, 0, 0);
      send(REQ_IGNORED, 63, 63, 63);
      send(scc_pkg::REQ_COMPUTE, 0, 0, 0);
      send(scc_pkg::REQ_READ, 0, 0, 63);
      send(scc_pkg::REQ_READ, 0, 0, 0);
      send(scc_pkg::REQ_EDGE, 0, 63, 0);
      send(scc_pkg::REQ_EDGE, 63, 0, 0);
      send(scc_pkg::REQ_EDGE, 63, 0, 0);
      send(scc_pkg::REQ_READ, 0, 0, 0);
      send(scc_pkg::REQ_EDGE, 5, 5, 0);
      send(scc_pkg::REQ_COMPUTE, 0, 0, 0);
      send(scc_pkg::REQ_READ, 0, 0, 0);
      send(scc_pkg::REQ_READ, 0, 0, 62);
      write_count(7'd3);
      send(scc_pkg::REQ_READ, 0, 0, 0);
      send(scc_pkg::REQ_EDGE, 0, 3, 0);
      send(scc_pkg::REQ_EDGE, 1, 2, 0);
      send(scc_pkg::REQ_EDGE, 2, 1, 0);
      send(scc_pkg::REQ_COMPUTE, 0, 0, 0);
      send(scc_pkg::REQ_READ, 0, 0, 0);
      send(scc_pkg::REQ_READ, 0, 0, 1);
      send(scc_pkg::REQ_READ, 0, 0, 2);
      write_count(7'd0);
      send(scc_pkg::REQ_EDGE, 0, 1, 0);
      send(scc_pkg::REQ_COMPUTE, 0, 0, 0);
      send(scc_pkg::REQ_READ, 0, 0, 0);
      write_count(7'd127);
      send(scc_pkg::REQ_COMPUTE, 0, 0, 0);
      send(scc_pkg::REQ_READ, 0, 0, 1);

      write_count(7'd8);
      random_phase(8, 500);
      write_count(7'd1);
      random_phase(1, 60);
      write_count(7'd20);
      random_phase(20, 500);
      drain();
      write_count(7'd64);
      random_phase(64, 400);
      write_count(7'd5);
      random_phase(5, 250);
      calm = 1;
      write_count(7'd12);
      random_phase(12, 250);
      drain();

      $display("covered %0d compute requests, %0d count writes, %0d responses checked",
               computes, config_writes, sb.checked);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("[ OK ] regression clean");
      else begin
         $display("%0d mismatches, %0d responses missing", sb.mismatches,
                  sb.pending.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
